/* sv/assert_macros.svh */
// Assertion macros used by the flattener RTL.
// No dependencies; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every cycle outside reset.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication outside reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* sv/cbf_pkg.sv */
// Package for the cubic Bezier flattener: types, constants, helpers.
// No dependencies.
package cbf_pkg;

  localparam int MAX_DEPTH_DEF = 6;
  localparam int COORD_W = 16;
  localparam int THRESH_W = 63;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 63'd7;

  typedef logic signed [COORD_W-1:0] coord_t;

  // One curve segment: four control points.
  typedef struct packed {
    coord_t x0, y0, x1, y1, x2, y2, x3, y3;
  } seg_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CROSS,
    ST_SQUARE,
    ST_DECIDE,
    ST_EMIT
  } state_t;

  // Floor of (a+b)/2.
  function automatic coord_t mid(input coord_t a, input coord_t b);
    logic signed [COORD_W:0] s;
    s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
    return s[COORD_W:1];
  endfunction

endpackage

/* sv/cbf_curve_if.sv */
// Valid/ready channel interfaces for curves, points and configuration.
// Depends on cbf_pkg.
interface cbf_curve_if;
  logic valid;
  logic ready;
  cbf_pkg::coord_t start_x, start_y, ctrl1_x, ctrl1_y;
  cbf_pkg::coord_t ctrl2_x, ctrl2_y, end_x, end_y;
  modport source (output valid, start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x,
                  ctrl2_y, end_x, end_y, input ready);
  modport sink (input valid, start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x,
                ctrl2_y, end_x, end_y, output ready);
endinterface

interface cbf_point_if;
  logic valid;
  logic ready;
  cbf_pkg::coord_t pt_x, pt_y;
  logic last_point;
  modport source (output valid, pt_x, pt_y, last_point, input ready);
  modport sink (input valid, pt_x, pt_y, last_point, output ready);
endinterface

interface cbf_cfg_if;
  logic valid;
  logic ready;
  logic [cbf_pkg::THRESH_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

/* sv/cbf_front.sv */
// Front end: accepts curves into a two-entry queue for the back end.
// Depends on cbf_pkg.
module cbf_front (
  input  logic           clk,
  input  logic           rst,
  cbf_curve_if.sink      curve,
  output logic           q_valid,
  output cbf_pkg::seg_t  q_seg,
  input  logic           q_pop
);
  cbf_pkg::seg_t mem [2];
  logic          wptr, rptr;
  logic [1:0]    count;
  logic          push;

  assign curve.ready = (count != 2'd2);
  assign push        = curve.valid && curve.ready;
  assign q_valid     = (count != 2'd0);
  assign q_seg       = mem[rptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= '{curve.start_x, curve.start_y, curve.ctrl1_x, curve.ctrl1_y,
                     curve.ctrl2_x, curve.ctrl2_y, curve.end_x, curve.end_y};
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (q_pop && q_valid) rptr <= ~rptr;
      count <= count + 2'(push) - 2'(q_pop && q_valid);
    end
  end
endmodule

/* sv/cbf_back.sv */
// Back end: depth-first subdivision with flatness test and a segment stack.
// Depends on cbf_pkg and assert_macros.svh.
`include "assert_macros.svh"
module cbf_back #(
  parameter int MAX_DEPTH = cbf_pkg::MAX_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [cbf_pkg::THRESH_W-1:0]  thresh,
  input  logic                          q_valid,
  input  cbf_pkg::seg_t                 q_seg,
  output logic                          q_pop,
  cbf_point_if.source                   pt
);
  localparam int LW = $clog2(MAX_DEPTH + 1);
  localparam int SW = $clog2(MAX_DEPTH + 1);
  localparam int PW = MAX_DEPTH + 1;

  cbf_pkg::state_t state, state_next;
  cbf_pkg::seg_t   seg;
  logic [LW-1:0]   level;
  logic [SW-1:0]   sp;
  logic [PW-1:0]   npts;
  logic signed [33:0] f1, f2;
  logic [63:0]     sq1, sq2;
  logic            big;
  logic            flat;
  logic            out_valid, out_last;
  cbf_pkg::coord_t out_x, out_y;

  cbf_pkg::seg_t   stk_seg [MAX_DEPTH];
  logic [LW-1:0]   stk_lvl [MAX_DEPTH];

  // cross-product operands
  logic signed [16:0] ax0, ay0, ax3, ay3, bx0, by0, bx3, by3;
  assign ax0 = 17'(seg.x0) - 17'(seg.x1);
  assign ay0 = 17'(seg.y0) - 17'(seg.y1);
  assign ax3 = 17'(seg.x3) - 17'(seg.x1);
  assign ay3 = 17'(seg.y3) - 17'(seg.y1);
  assign bx0 = 17'(seg.x0) - 17'(seg.x2);
  assign by0 = 17'(seg.y0) - 17'(seg.y2);
  assign bx3 = 17'(seg.x3) - 17'(seg.x2);
  assign by3 = 17'(seg.y3) - 17'(seg.y2);

  // subdivision
  cbf_pkg::coord_t mxa, mya, mxb, myb, mxc, myc, mxd, myd, mxe, mye, mxm, mym;
  assign mxa = cbf_pkg::mid(seg.x0, seg.x1);
  assign mya = cbf_pkg::mid(seg.y0, seg.y1);
  assign mxb = cbf_pkg::mid(seg.x1, seg.x2);
  assign myb = cbf_pkg::mid(seg.y1, seg.y2);
  assign mxc = cbf_pkg::mid(seg.x2, seg.x3);
  assign myc = cbf_pkg::mid(seg.y2, seg.y3);
  assign mxd = cbf_pkg::mid(mxa, mxb);
  assign myd = cbf_pkg::mid(mya, myb);
  assign mxe = cbf_pkg::mid(mxb, mxc);
  assign mye = cbf_pkg::mid(myb, myc);
  assign mxm = cbf_pkg::mid(mxd, mxe);
  assign mym = cbf_pkg::mid(myd, mye);

  // flatness compare on registered squares
  logic [64:0] ssum;
  assign ssum = {1'b0, sq1} + {1'b0, sq2};
  assign flat = (level >= LW'(MAX_DEPTH)) ||
                (!big && !ssum[64] && (ssum[63:0] < {1'b0, thresh}));

  assign pt.valid      = out_valid;
  assign pt.pt_x       = out_x;
  assign pt.pt_y       = out_y;
  assign pt.last_point = out_last;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= cbf_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    unique case (state)
      cbf_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = cbf_pkg::ST_CROSS;
        end
      end
      cbf_pkg::ST_CROSS:  state_next = cbf_pkg::ST_SQUARE;
      cbf_pkg::ST_SQUARE: state_next = cbf_pkg::ST_DECIDE;
      cbf_pkg::ST_DECIDE: state_next = flat ? cbf_pkg::ST_EMIT : cbf_pkg::ST_CROSS;
      cbf_pkg::ST_EMIT: begin
        if (!out_valid || pt.ready)
          state_next = (sp == '0 || npts == PW'(1 << MAX_DEPTH)) ?
                       cbf_pkg::ST_IDLE : cbf_pkg::ST_CROSS;
      end
      default: state_next = cbf_pkg::ST_IDLE;
    endcase
  end

  // datapath and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sp        <= '0;
    end else begin
      if (out_valid && pt.ready && state != cbf_pkg::ST_EMIT) out_valid <= 1'b0;
      unique case (state)
        cbf_pkg::ST_IDLE: begin
          if (q_valid) begin
            seg   <= q_seg;
            level <= '0;
            sp    <= '0;
            npts  <= '0;
          end
        end
        cbf_pkg::ST_CROSS: begin
          f1 <= 34'(ax0 * ay3) - 34'(ay0 * ax3);
          f2 <= 34'(bx0 * by3) - 34'(by0 * bx3);
        end
        cbf_pkg::ST_SQUARE: begin
          big <= ((f1 < 0 ? -f1 : f1) >= 34'sh100000000) ||
                 ((f2 < 0 ? -f2 : f2) >= 34'sh100000000);
          sq1 <= 64'(f1 * f1);
          sq2 <= 64'(f2 * f2);
        end
        cbf_pkg::ST_DECIDE: begin
          if (!flat) begin
            if (sp < SW'(MAX_DEPTH)) begin
              stk_seg[sp[SW-1:0]] <= '{mxm, mym, mxe, mye, mxc, myc, seg.x3, seg.y3};
              stk_lvl[sp[SW-1:0]] <= level + LW'(1);
              sp <= sp + SW'(1);
            end
            seg   <= '{seg.x0, seg.y0, mxa, mya, mxd, myd, mxm, mym};
            level <= level + LW'(1);
          end
        end
        cbf_pkg::ST_EMIT: begin
          if (!out_valid || pt.ready) begin
            out_valid <= 1'b1;
            out_x     <= seg.x3;
            out_y     <= seg.y3;
            npts      <= npts + PW'(1);
            out_last  <= (sp == '0) || (npts + PW'(1) == PW'(1 << MAX_DEPTH));
            if (sp != '0) begin
              seg   <= stk_seg[sp - SW'(1)];
              level <= stk_lvl[sp - SW'(1)];
              sp    <= sp - SW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  `ASSERT_IMPL(a_sp_bound, clk, rst, 1'b1, sp <= SW'(MAX_DEPTH))
  `ASSERT_IMPL(a_lvl_bound, clk, rst, state != cbf_pkg::ST_IDLE, level <= LW'(MAX_DEPTH))
  `ASSERT_NEXT(a_pop_start, clk, rst, q_pop, state == cbf_pkg::ST_CROSS)
endmodule

/* sv/cubic_bezier_flattener.sv */
// Cubic Bezier flattener: one curve in, 1 to 2^MAX_DEPTH polyline points out.
// Each test/split step passes through the cross-product, square and compare
// states, and each emitted point through the emit state, which waits on
// point back-pressure. A two-entry input queue takes the next curves while
// the subdivision sequencer works.
// Depends on cbf_pkg, the channel interfaces, cbf_front and cbf_back.
module cubic_bezier_flattener #(
  parameter int MAX_DEPTH = cbf_pkg::MAX_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  cbf_curve_if.sink   curve,
  cbf_point_if.source pt,
  cbf_cfg_if.sink     cfg
);
  logic [cbf_pkg::THRESH_W-1:0] thresh;
  logic          q_valid, q_pop;
  cbf_pkg::seg_t q_seg;

  // threshold register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) thresh <= cbf_pkg::THRESH_RESET;
    else if (cfg.valid) thresh <= cfg.data;
  end

  cbf_front u_front (.clk, .rst, .curve, .q_valid, .q_seg, .q_pop);

  cbf_back #(.MAX_DEPTH(MAX_DEPTH)) u_back (
    .clk, .rst, .thresh, .q_valid, .q_seg, .q_pop, .pt
  );
endmodule

/* tb/sv/tb_top.sv */
// Self-checking bench for cubic_bezier_flattener: curves in, polyline points out.
// Depends on cbf_pkg, the cbf_curve_if, cbf_point_if and cbf_cfg_if interfaces and cubic_bezier_flattener.
`timescale 1ns / 1ps

module tb_top;

  localparam int DEPTH_CAP = cbf_pkg::MAX_DEPTH_DEF;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 600;

  typedef struct {
    cbf_pkg::coord_t x;
    cbf_pkg::coord_t y;
    logic            last;
  } point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cbf_curve_if curve ();
  cbf_point_if pt ();
  cbf_cfg_if   cfg ();

  cubic_bezier_flattener dut (
    .clk  (clk),
    .rst  (rst),
    .curve(curve.sink),
    .pt   (pt.source),
    .cfg  (cfg.sink)
  );

  cbf_pkg::seg_t                curves_pending[$];
  point_t                       points_expected[$];
  logic [cbf_pkg::THRESH_W-1:0] thresh_writes[$];
  logic [cbf_pkg::THRESH_W-1:0] flat_limit = cbf_pkg::THRESH_RESET;
  bit                    steady = 1'b0;  // no idling on either side
  bit                    hold_curves = 1'b0;
  int                    fail_count = 0;
  int                    curves_done = 0;
  int                    points_done = 0;
  int                    quiet_cycles = 0;

  // Clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on point %0d: %s got %0d expected %0d", points_done, what, got,
             want);
    fail_count++;
  endtask

  // Floor of (a+b)/2
  function automatic int half_sum(input int a, input int b);
    return (a + b) >>> 1;
  endfunction

  function automatic bit seg_is_flat(input int s[8]);
    longint      f1, f2;
    logic [63:0] a1, a2;
    logic [64:0] sq1, sq2, total;
    f1 = longint'(s[0] - s[2]) * (s[7] - s[3]) - longint'(s[1] - s[3]) * (s[6] - s[2]);
    f2 = longint'(s[0] - s[4]) * (s[7] - s[5]) - longint'(s[1] - s[5]) * (s[6] - s[4]);
    a1 = (f1 < 0) ? -f1 : f1;
    a2 = (f2 < 0) ? -f2 : f2;
    if (a1 >= 64'h1_0000_0000 || a2 >= 64'h1_0000_0000) return 1'b0;
    sq1 = a1 * a1;
    sq2 = a2 * a2;
    total = sq1 + sq2;
    if (total[64]) total = {1'b0, {64{1'b1}}};
    return total < {2'b00, flat_limit};
  endfunction

  // Depth-first subdivision of one curve; queues every point it emits
  function automatic void flatten_curve(input cbf_pkg::seg_t c);
    int s[8];
    int right[8];
    int stk[DEPTH_CAP][8];
    int stk_lvl[DEPTH_CAP];
    int top, lvl, n;
    int ax, ay, bx, by, cx, cy, dx, dy, ex, ey, mx, my;
    point_t p;
    s = '{c.x0, c.y0, c.x1, c.y1, c.x2, c.y2, c.x3, c.y3};
    top = 0;
    lvl = 0;
    n = 0;
    forever begin
      if (lvl >= DEPTH_CAP || seg_is_flat(s)) begin
        n++;
        p.x = cbf_pkg::coord_t'(s[6]);
        p.y = cbf_pkg::coord_t'(s[7]);
        p.last = (top == 0 || n >= (1 << DEPTH_CAP));
        points_expected.push_back(p);
        if (p.last) break;
        top--;
        s = stk[top];
        lvl = stk_lvl[top];
      end else begin
        ax = half_sum(s[0], s[2]); ay = half_sum(s[1], s[3]);
        bx = half_sum(s[2], s[4]); by = half_sum(s[3], s[5]);
        cx = half_sum(s[4], s[6]); cy = half_sum(s[5], s[7]);
        dx = half_sum(ax, bx);     dy = half_sum(ay, by);
        ex = half_sum(bx, cx);     ey = half_sum(by, cy);
        mx = half_sum(dx, ex);     my = half_sum(dy, ey);
        right = '{mx, my, ex, ey, cx, cy, s[6], s[7]};
        if (top < DEPTH_CAP) begin
          stk[top] = right;
          stk_lvl[top] = lvl + 1;
          top++;
        end
        s[2] = ax; s[3] = ay; s[4] = dx; s[5] = dy; s[6] = mx; s[7] = my;
        lvl++;
      end
    end
  endfunction

  // Curve driver
  always @(posedge clk) begin
    if (rst) begin
      curve.valid <= 1'b0;
    end else begin
      if (curve.valid && curve.ready) begin
        flatten_curve(curves_pending.pop_front());
        curves_done++;
      end
      if (curve.valid && !curve.ready) begin
        curve.valid <= 1'b1;
      end else if (curves_pending.size() > 0 && !hold_curves &&
                   (steady || $urandom_range(99) >= 18)) begin
        curve.valid   <= 1'b1;
        curve.start_x <= curves_pending[0].x0;
        curve.start_y <= curves_pending[0].y0;
        curve.ctrl1_x <= curves_pending[0].x1;
        curve.ctrl1_y <= curves_pending[0].y1;
        curve.ctrl2_x <= curves_pending[0].x2;
        curve.ctrl2_y <= curves_pending[0].y2;
        curve.end_x   <= curves_pending[0].x3;
        curve.end_y   <= curves_pending[0].y3;
      end else begin
        curve.valid <= 1'b0;
      end
    end
  end

  // Threshold register writes
  always @(posedge clk) begin
    if (rst) begin
      cfg.valid <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        flat_limit = cfg.data;
        void'(thresh_writes.pop_front());
      end
      if (cfg.valid && !cfg.ready) begin
        cfg.valid <= 1'b1;
      end else if (!(cfg.valid && cfg.ready) && thresh_writes.size() > 0) begin
        cfg.valid <= 1'b1;
        cfg.data  <= thresh_writes[0];
      end else begin
        cfg.valid <= 1'b0;
      end
    end
  end

  // Point monitor and checker
  always @(posedge clk) begin
    point_t want;
    if (rst) begin
      pt.ready <= 1'b0;
    end else begin
      if (pt.valid && pt.ready) begin
        if (points_expected.size() == 0) begin
          report_mismatch("unexpected pt_x", pt.pt_x, 0);
        end else begin
          want = points_expected.pop_front();
          if (pt.pt_x !== want.x) report_mismatch("pt_x", pt.pt_x, want.x);
          if (pt.pt_y !== want.y) report_mismatch("pt_y", pt.pt_y, want.y);
          if (pt.last_point !== want.last)
            report_mismatch("last_point", pt.last_point, want.last);
        end
        points_done++;
      end
      pt.ready <= steady || $urandom_range(99) >= 18;
    end
  end

  // Watchdog on cycles without any accepted request
  always @(posedge clk) begin
    if ((curve.valid && curve.ready) || (pt.valid && pt.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: nothing accepted for %0d cycles", STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic cbf_pkg::seg_t make_seg(input int x0, y0, x1, y1, x2, y2, x3, y3);
    cbf_pkg::seg_t c;
    c.x0 = cbf_pkg::coord_t'(x0); c.y0 = cbf_pkg::coord_t'(y0);
    c.x1 = cbf_pkg::coord_t'(x1); c.y1 = cbf_pkg::coord_t'(y1);
    c.x2 = cbf_pkg::coord_t'(x2); c.y2 = cbf_pkg::coord_t'(y2);
    c.x3 = cbf_pkg::coord_t'(x3); c.y3 = cbf_pkg::coord_t'(y3);
    return c;
  endfunction

  // Mostly full-range curves, some small ones that flatten at moderate depth
  function automatic cbf_pkg::seg_t rand_seg();
    cbf_pkg::seg_t c;
    int   span;
    c = cbf_pkg::seg_t'({$urandom, $urandom, $urandom, $urandom});
    if ($urandom_range(99) < 40) begin
      span = 1 << $urandom_range(2, 11);
      c = make_seg($urandom_range(0, 2 * span) - span, $urandom_range(0, 2 * span) - span,
                   $urandom_range(0, 2 * span) - span, $urandom_range(0, 2 * span) - span,
                   $urandom_range(0, 2 * span) - span, $urandom_range(0, 2 * span) - span,
                   $urandom_range(0, 2 * span) - span, $urandom_range(0, 2 * span) - span);
    end
    return c;
  endfunction

  task automatic wait_drained();
    wait (curves_pending.size() == 0 && !curve.valid && points_expected.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_threshold(input logic [cbf_pkg::THRESH_W-1:0] v);
    thresh_writes.push_back(v);
    wait (thresh_writes.size() == 0);
    @(posedge clk);
  endtask

  task automatic random_phase(input int count);
    repeat (count) curves_pending.push_back(rand_seg());
    wait_drained();
  endtask

  // Stimulus sequence
  initial begin
    curve.valid = 1'b0;
    curve.start_x = '0; curve.start_y = '0; curve.ctrl1_x = '0; curve.ctrl1_y = '0;
    curve.ctrl2_x = '0; curve.ctrl2_y = '0; curve.end_x = '0; curve.end_y = '0;
    pt.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed curves at the reset threshold
    curves_pending.push_back(make_seg(0, 0, 0, 0, 0, 0, 0, 0));
    curves_pending.push_back(make_seg(32767, 32767, 32767, 32767, 32767, 32767, 32767,
                                      32767));
    curves_pending.push_back(make_seg(-32768, -32768, -32768, -32768, -32768, -32768,
                                      -32768, -32768));
    // sum of squares overflows
    curves_pending.push_back(make_seg(-32768, -32768, 32767, -32768, -32768, 32767,
                                      32767, 32767));
    curves_pending.push_back(make_seg(-32768, 32767, 32767, -32768, -32768, -32768,
                                      32767, 32767));
    // straight line, flat at once
    curves_pending.push_back(make_seg(0, 0, 16, 16, 32, 32, 48, 48));
    // odd negative sums for floor midpoints
    curves_pending.push_back(make_seg(-1, -3, -5, 7, -9, -11, 13, -15));
    curves_pending.push_back(make_seg(-100, 50, 3, -77, 255, 1, -31, -63));
    curves_pending.push_back(make_seg(32767, -32768, -32768, 32767, 32767, -32768,
                                      -32768, 32767));
    repeat (6) curves_pending.push_back(rand_seg());
    wait_drained();

    // Never flat: every curve gives the full point count
    set_threshold('0);
    curves_pending.push_back(make_seg(0, 0, 0, 0, 0, 0, 0, 0));
    random_phase(15);

    // Always flat apart from overflow
    set_threshold({cbf_pkg::THRESH_W{1'b1}});
    curves_pending.push_back(make_seg(-32768, -32768, 32767, -32768, -32768, 32767,
                                      32767, 32767));
    random_phase(25);

    // No idling on either side
    steady = 1'b1;
    set_threshold(63'd1 << 20);
    random_phase(35);
    steady = 1'b0;

    // Sender holds partway until the block is empty
    set_threshold(63'd7);
    repeat (12) curves_pending.push_back(rand_seg());
    wait (curves_pending.size() <= 6);
    hold_curves = 1'b1;
    wait (!curve.valid && points_expected.size() == 0);
    hold_curves = 1'b0;
    wait_drained();

    repeat (2) begin
      set_threshold(63'({$urandom, $urandom} >> $urandom_range(0, 62)));
      random_phase(25);
    end

    $display("covered %0d curves and %0d points over thresholds from zero to full scale",
             curves_done, points_done);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
